/* rtl/keyed_reader_writer_lock_table_top_assert.svh */
// Assertion macros for the keyed reader/writer lock table.
// Used by the controller and datapath modules; depends on clk and arst_n in scope.
`ifndef KEYED_READER_WRITER_LOCK_TABLE_TOP_ASSERT_SVH
`define KEYED_READER_WRITER_LOCK_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define KRWL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define KRWL_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define KRWL_ASSERT(label, prop, msg)
`define KRWL_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

/* rtl/krwl_pkg.sv */
// Shared types and codes for the keyed reader/writer lock table.
// Used by krwl_ctrl, krwl_dp and the top level; depends on nothing.
package krwl_pkg;

	localparam int KeyW   = 64;
	localparam int CountW = 9;
	localparam int CountCap = 255;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ACQUIRE = 2'd0;
	localparam kind_t KIND_RELEASE = 2'd1;
	localparam kind_t KIND_TEST    = 2'd2;
	localparam kind_t KIND_UNUSED  = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK           = 3'd0;
	localparam status_t ST_CONFLICT     = 3'd1;
	localparam status_t ST_FULL         = 3'd2;
	localparam status_t ST_READERS_FULL = 3'd3;
	localparam status_t ST_MISMATCH     = 3'd4;

	typedef logic signed [CountW-1:0] count_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

endpackage

/* rtl/krwl_ctrl.sv */
// Controller state machine for the keyed reader/writer lock table.
// Depends on krwl_pkg and the assertion macro header.
`include "keyed_reader_writer_lock_table_top_assert.svh"

module krwl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output krwl_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.lookup = (state_q == S_LOOKUP);
		cmd.commit = (state_q == S_UPDATE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					// The result is written only once the output register is free.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`KRWL_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.lookup, cmd.commit}), "commands overlap")
	`KRWL_ASSERT_NEXT(a_accept_lookup, in_valid && !in_stall, cmd.lookup, "no lookup after accept")
	`KRWL_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid, "commit did not raise out_valid")

endmodule

/* rtl/krwl_dp.sv */
// Datapath of the keyed reader/writer lock table: item registers, the
// associative entry store, the decision logic and the result register.
// Depends on krwl_pkg and the assertion macro header.
`include "keyed_reader_writer_lock_table_top_assert.svh"

module krwl_dp #(
	parameter int ENTRIES    = 16,
	parameter int READER_MAX = 255
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  krwl_pkg::ctrl_cmd_t                cmd,
	input  krwl_pkg::kind_t                    kind,
	input  logic [krwl_pkg::KeyW-1:0]          object_id,
	input  logic                               mode,
	output logic                               answer,
	output krwl_pkg::status_t                  status,
	output logic signed [krwl_pkg::CountW-1:0] holders
);

	localparam int LimCapped = (READER_MAX > krwl_pkg::CountCap) ? krwl_pkg::CountCap
		: READER_MAX;
	localparam int LimFinal = (LimCapped < 1) ? 1 : LimCapped;
	localparam krwl_pkg::count_t ReaderLimit = krwl_pkg::count_t'(LimFinal);

	// Item registers.
	krwl_pkg::kind_t           kind_s1;
	logic [krwl_pkg::KeyW-1:0] key_s1;
	logic                      mode_s1;

	// Entry store.
	logic [ENTRIES-1:0]        valid_q;
	logic [krwl_pkg::KeyW-1:0] key_q [ENTRIES];
	krwl_pkg::count_t          cnt_q [ENTRIES];

	// Lookup results.
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] free_vec;
	krwl_pkg::count_t   hit_cnt;
	logic [ENTRIES-1:0] hit_vec_s2;
	logic [ENTRIES-1:0] free_vec_s2;
	logic               hit_s2;
	logic               free_any_s2;
	krwl_pkg::count_t   cnt_s2;

	// Decision.
	logic              nx_answer;
	krwl_pkg::status_t nx_status;
	krwl_pkg::count_t  nx_holders;
	logic              do_alloc;
	logic              do_write;
	logic              do_free;
	krwl_pkg::count_t  wr_cnt;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_s1 <= kind;
			key_s1  <= object_id;
			mode_s1 <= mode;
		end
	end

	always_comb begin
		hit_cnt = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_s1);
			if (match[i]) begin
				hit_cnt = hit_cnt | cnt_q[i];
			end
		end
	end

	// Lowest clear bit of the valid vector.
	assign free_vec = ~valid_q & (valid_q + ENTRIES'(1));

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_vec_s2  <= match;
			free_vec_s2 <= free_vec;
			hit_s2      <= |match;
			free_any_s2 <= |free_vec;
			cnt_s2      <= hit_cnt;
		end
	end

	always_comb begin
		nx_answer  = 1'b0;
		nx_status  = krwl_pkg::ST_OK;
		nx_holders = hit_s2 ? cnt_s2 : '0;
		do_alloc   = 1'b0;
		do_write   = 1'b0;
		do_free    = 1'b0;
		wr_cnt     = mode_s1 ? krwl_pkg::count_t'(-1) : krwl_pkg::count_t'(1);
		unique case (kind_s1)
			krwl_pkg::KIND_ACQUIRE: begin
				if (!hit_s2) begin
					if (!free_any_s2) begin
						nx_status = krwl_pkg::ST_FULL;
					end else begin
						do_alloc   = 1'b1;
						nx_answer  = 1'b1;
						nx_holders = wr_cnt;
					end
				end else if (!mode_s1 && (cnt_s2 > 0)) begin
					if (cnt_s2 >= ReaderLimit) begin
						nx_status = krwl_pkg::ST_READERS_FULL;
					end else begin
						wr_cnt     = cnt_s2 + krwl_pkg::count_t'(1);
						do_write   = 1'b1;
						nx_answer  = 1'b1;
						nx_holders = wr_cnt;
					end
				end else begin
					nx_status = krwl_pkg::ST_CONFLICT;
				end
			end
			krwl_pkg::KIND_RELEASE: begin
				if (!hit_s2) begin
					nx_status = krwl_pkg::ST_MISMATCH;
				end else if (!mode_s1 && (cnt_s2 > 0)) begin
					wr_cnt    = cnt_s2 - krwl_pkg::count_t'(1);
					nx_answer = 1'b1;
					if (cnt_s2 == krwl_pkg::count_t'(1)) begin
						do_free    = 1'b1;
						nx_holders = '0;
					end else begin
						do_write   = 1'b1;
						nx_holders = wr_cnt;
					end
				end else if (mode_s1 && (cnt_s2 == krwl_pkg::count_t'(-1))) begin
					do_free    = 1'b1;
					nx_answer  = 1'b1;
					nx_holders = '0;
				end else begin
					nx_status = krwl_pkg::ST_MISMATCH;
				end
			end
			krwl_pkg::KIND_TEST: begin
				nx_answer = mode_s1 ? hit_s2 : (hit_s2 && (cnt_s2 < 0));
			end
			krwl_pkg::KIND_UNUSED: begin
				nx_answer = 1'b0;
			end
			default: begin
				nx_answer = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (do_alloc) begin
				valid_q <= valid_q | free_vec_s2;
			end else if (do_free) begin
				valid_q <= valid_q & ~hit_vec_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.commit && do_alloc && free_vec_s2[i]) begin
				key_q[i] <= key_s1;
				cnt_q[i] <= wr_cnt;
			end else if (cmd.commit && do_write && hit_vec_s2[i]) begin
				cnt_q[i] <= wr_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			answer  <= nx_answer;
			status  <= nx_status;
			holders <= nx_holders;
		end
	end

	`KRWL_ASSERT(a_key_unique, $onehot0(match), "one key held in two entries")
	`KRWL_ASSERT(a_free_onehot, $onehot0(free_vec), "free slot vector not one-hot")
	`KRWL_ASSERT_NEXT(a_alloc_valid, cmd.commit && do_alloc, |(valid_q & free_vec_s2), "alloc lost")

endmodule

/* rtl/keyed_reader_writer_lock_table_top.sv */
// Top level of the keyed reader/writer lock table.
// Instantiates krwl_ctrl and krwl_dp; depends on krwl_pkg.
//
// Usage: one request item enters on the input channel (kind, object_id, mode)
// and one result item (answer, status, holders) leaves on the output channel.
// Both channels move an item on a rising edge with valid high and stall low.
//
// Steps: an accepted item is loaded into the item registers, looked up against all
// entries in parallel and committed to the entry store and the result register;
// its result is then valid. The controller handles one item at a time through its
// load, lookup and commit steps and takes no new item until the last has committed.
// The result sits in an output register, so the next item is taken while a
// result waits. When the receiver stalls, the result holds and a later item
// waits in its commit step until the output register is free.
//
// Reset clears all entry valid bits at once; there is no clearing pass. Key
// and count storage is written on allocation (counts also on updates) and read only while valid.
module keyed_reader_writer_lock_table_top #(
	parameter int ENTRIES    = 16,
	parameter int READER_MAX = 255
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  krwl_pkg::kind_t                    kind,
	input  logic [krwl_pkg::KeyW-1:0]          object_id,
	input  logic                               mode,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               answer,
	output krwl_pkg::status_t                  status,
	output logic signed [krwl_pkg::CountW-1:0] holders
);

	krwl_pkg::ctrl_cmd_t cmd;

	krwl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	krwl_dp #(
		.ENTRIES    (ENTRIES),
		.READER_MAX (READER_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.kind      (kind),
		.object_id (object_id),
		.mode      (mode),
		.answer    (answer),
		.status    (status),
		.holders   (holders)
	);

endmodule

/* tb/keyed_reader_writer_lock_table_top_tb.sv */
// Self-checking testbench for the keyed reader/writer lock table top level.
// Depends on krwl_pkg and keyed_reader_writer_lock_table_top; a scoreboard with
// its own lock table checks every result item under random pacing on both sides.
`timescale 1ns / 1ps

module keyed_reader_writer_lock_table_top_tb;
	import krwl_pkg::*;

	localparam int Entries      = 16;
	localparam int ReaderMax    = 255;
	localparam int ReaderLimit  = (ReaderMax > CountCap) ? CountCap :
	                              ((ReaderMax < 1) ? 1 : ReaderMax);
	localparam int ItemTarget   = 1550;
	localparam int PoolSize     = 24;
	localparam int IdleLimit    = 3000;
	localparam int DrainCycles  = 20;

	localparam logic MODE_SHARED = 1'b0;
	localparam logic MODE_EXCL   = 1'b1;

	localparam logic [KeyW-1:0] KeyLow  = '0;
	localparam logic [KeyW-1:0] KeyHigh = '1;
	localparam logic [KeyW-1:0] KeyMid  = 64'h8000_0000_0000_0001;

	typedef struct packed {
		logic    answer;
		status_t status;
		count_t  holders;
	} lock_result_t;

	typedef struct packed {
		kind_t           op;
		logic [KeyW-1:0] id;
		logic            excl;
		logic            typed;
		logic            answer;
		status_t         status;
		count_t          holders;
	} lock_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	kind_t             kind;
	logic [KeyW-1:0]   object_id;
	logic              mode;
	logic              out_valid;
	logic              out_stall;
	logic              answer;
	status_t           status;
	logic signed [CountW-1:0] holders;

	// Shadow copy of the lock table.
	logic              held_valid [Entries];
	logic [KeyW-1:0]   held_key   [Entries];
	int                held_count [Entries];

	lock_result_t      pending_results [$];
	logic [KeyW-1:0]   key_pool [PoolSize];
	int                items_sent;
	int                error_count;
	int                idle_cycles;
	logic              steady_sender;

	// Rows with a typed result are checked against it; the rest use the shadow table.
	lock_row_t directed_rows [23] = '{
		'{KIND_TEST,    KeyLow,  MODE_EXCL,   1'b1, 1'b0, ST_OK,       9'sd0},
		'{KIND_TEST,    KeyHigh, MODE_SHARED, 1'b1, 1'b0, ST_OK,       9'sd0},
		'{KIND_RELEASE, KeyLow,  MODE_SHARED, 1'b1, 1'b0, ST_MISMATCH, 9'sd0},
		'{KIND_RELEASE, KeyHigh, MODE_EXCL,   1'b1, 1'b0, ST_MISMATCH, 9'sd0},
		'{KIND_ACQUIRE, KeyLow,  MODE_SHARED, 1'b1, 1'b1, ST_OK,       9'sd1},
		'{KIND_ACQUIRE, KeyLow,  MODE_SHARED, 1'b1, 1'b1, ST_OK,       9'sd2},
		'{KIND_TEST,    KeyLow,  MODE_SHARED, 1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_TEST,    KeyLow,  MODE_EXCL,   1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_ACQUIRE, KeyLow,  MODE_EXCL,   1'b1, 1'b0, ST_CONFLICT, 9'sd2},
		'{KIND_RELEASE, KeyLow,  MODE_EXCL,   1'b1, 1'b0, ST_MISMATCH, 9'sd2},
		'{KIND_ACQUIRE, KeyHigh, MODE_EXCL,   1'b1, 1'b1, ST_OK,       -9'sd1},
		'{KIND_ACQUIRE, KeyHigh, MODE_SHARED, 1'b1, 1'b0, ST_CONFLICT, -9'sd1},
		'{KIND_ACQUIRE, KeyHigh, MODE_EXCL,   1'b1, 1'b0, ST_CONFLICT, -9'sd1},
		'{KIND_TEST,    KeyHigh, MODE_SHARED, 1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_RELEASE, KeyHigh, MODE_SHARED, 1'b1, 1'b0, ST_MISMATCH, -9'sd1},
		'{KIND_UNUSED,  KeyHigh, MODE_EXCL,   1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_UNUSED,  KeyMid,  MODE_SHARED, 1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_RELEASE, KeyHigh, MODE_EXCL,   1'b1, 1'b1, ST_OK,       9'sd0},
		'{KIND_RELEASE, KeyLow,  MODE_SHARED, 1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_RELEASE, KeyLow,  MODE_SHARED, 1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_TEST,    KeyLow,  MODE_EXCL,   1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_ACQUIRE, KeyMid,  MODE_EXCL,   1'b0, 1'b0, ST_OK,       9'sd0},
		'{KIND_RELEASE, KeyMid,  MODE_EXCL,   1'b0, 1'b0, ST_OK,       9'sd0}
	};

	keyed_reader_writer_lock_table_top #(
		.ENTRIES   (Entries),
		.READER_MAX(ReaderMax)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.object_id(object_id),
		.mode     (mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.answer   (answer),
		.status   (status),
		.holders  (holders)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_held(logic [KeyW-1:0] id);
		for (int s = 0; s < Entries; s++)
			if (held_valid[s] && held_key[s] == id)
				return s;
		return -1;
	endfunction

	// Applies one request to the shadow table and returns the result it gives.
	function automatic lock_result_t predict_lock_result(kind_t op, logic [KeyW-1:0] id,
		logic excl);
		lock_result_t r;
		int s;
		int f;
		r.answer = 1'b0;
		r.status = ST_OK;
		s = find_held(id);
		case (op)
			KIND_ACQUIRE: begin
				if (s < 0) begin
					f = -1;
					for (int e = Entries - 1; e >= 0; e--)
						if (!held_valid[e])
							f = e;
					if (f < 0) begin
						r.status = ST_FULL;
					end else begin
						held_valid[f] = 1'b1;
						held_key[f]   = id;
						held_count[f] = excl ? -1 : 1;
						r.answer      = 1'b1;
						s             = f;
					end
				end else if (!excl && held_count[s] > 0) begin
					if (held_count[s] >= ReaderLimit) begin
						r.status = ST_READERS_FULL;
					end else begin
						held_count[s]++;
						r.answer = 1'b1;
					end
				end else begin
					r.status = ST_CONFLICT;
				end
			end
			KIND_RELEASE: begin
				if (s < 0) begin
					r.status = ST_MISMATCH;
				end else if (!excl && held_count[s] > 0) begin
					held_count[s]--;
					if (held_count[s] == 0) begin
						held_valid[s] = 1'b0;
						s = -1;
					end
					r.answer = 1'b1;
				end else if (excl && held_count[s] == -1) begin
					held_valid[s] = 1'b0;
					s = -1;
					r.answer = 1'b1;
				end else begin
					r.status = ST_MISMATCH;
				end
			end
			KIND_TEST: begin
				if (excl)
					r.answer = (s >= 0);
				else
					r.answer = (s >= 0) && (held_count[s] < 0);
			end
			default: ;
		endcase
		r.holders = (s >= 0) ? count_t'(held_count[s]) : '0;
		return r;
	endfunction

	function automatic int sender_gap();
		int r;
		if (steady_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offers one item and waits for it to be taken; the expectation is queued on acceptance.
	task automatic send_item(kind_t op, logic [KeyW-1:0] id, logic excl, logic typed,
		lock_result_t typed_result);
		int gap;
		logic taken;
		lock_result_t predicted;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= op;
		object_id <= id;
		mode      <= excl;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predicted = predict_lock_result(op, id, excl);
		pending_results.push_back(typed ? typed_result : predicted);
		items_sent++;
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic wait_until_settled();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Releases every held lock with the matching mode, one reader at a time.
	task automatic drain_table();
		logic [KeyW-1:0] keys [$];
		logic modes [$];
		for (int s = 0; s < Entries; s++) begin
			if (held_valid[s]) begin
				if (held_count[s] < 0) begin
					keys.push_back(held_key[s]);
					modes.push_back(MODE_EXCL);
				end else begin
					for (int r = 0; r < held_count[s]; r++) begin
						keys.push_back(held_key[s]);
						modes.push_back(MODE_SHARED);
					end
				end
			end
		end
		foreach (keys[i])
			send_item(KIND_RELEASE, keys[i], modes[i], 1'b0, '0);
	endtask

	task automatic check_field(string what, logic signed [15:0] want,
		logic signed [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			error_count++;
		end
	endtask

	// Results are sampled mid-cycle, where the handshake for the next edge is settled.
	always @(negedge clk) begin : result_check
		lock_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item, answer %0d status %0d holders %0d",
					$time, answer, status, holders);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("answer", 16'(want.answer), 16'(answer));
				check_field("status", 16'(want.status), 16'(status));
				check_field("holders", 16'(want.holders), 16'(holders));
			end
		end
	end

	always @(negedge clk) begin : watchdog
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no item moved for %0d cycles", $time, IdleLimit);
			$display("keyed_reader_writer_lock_table_top_tb: FAIL");
			$finish;
		end
	end

	// Receiver pacing: spans with no stall, light or heavy random stall, or one long stall.
	initial begin : receiver_pacing
		int span;
		int style;
		int c;
		out_stall = 1'b0;
		forever begin
			style = $urandom_range(0, 9);
			span  = (style == 9) ? $urandom_range(20, 40) : $urandom_range(8, 60);
			for (c = 0; c < span; c++) begin
				@(posedge clk);
				if (style <= 2)
					out_stall <= 1'b0;
				else if (style <= 6)
					out_stall <= ($urandom_range(0, 3) == 0);
				else if (style <= 8)
					out_stall <= ($urandom_range(0, 9) < 7);
				else
					out_stall <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int len;
		int pick;
		int free_slots;
		int held_slots [$];
		logic [KeyW-1:0] flood_key;
		logic flood_done;
		lock_result_t typed_result;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_ACQUIRE;
		object_id     = '0;
		mode          = MODE_SHARED;
		items_sent    = 0;
		error_count   = 0;
		idle_cycles   = 0;
		steady_sender = 1'b0;
		flood_done    = 1'b0;
		for (int s = 0; s < Entries; s++)
			held_valid[s] = 1'b0;

		// A small pool keeps keys colliding; half the pool differs from one key by one bit.
		key_pool[0] = KeyLow;
		key_pool[1] = KeyHigh;
		for (int p = 2; p < 12; p++)
			key_pool[p] = {$urandom, $urandom};
		for (int p = 12; p < PoolSize; p++)
			key_pool[p] = key_pool[2] ^ (64'h1 << $urandom_range(0, KeyW - 1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			typed_result = '{directed_rows[r].answer, directed_rows[r].status,
				directed_rows[r].holders};
			send_item(directed_rows[r].op, directed_rows[r].id, directed_rows[r].excl,
				directed_rows[r].typed, typed_result);
		end

		while (items_sent < ItemTarget) begin
			steady_sender = ($urandom_range(0, 3) == 0);
			if (!flood_done && items_sent >= 400) begin
				// Try to push one key's reader count past the limit, then release past zero.
				flood_done = 1'b1;
				drain_table();
				wait_until_settled();
				flood_key = {$urandom, $urandom};
				repeat (ReaderLimit + 2)
					send_item(KIND_ACQUIRE, flood_key, MODE_SHARED, 1'b0, '0);
				send_item(KIND_TEST, flood_key, MODE_EXCL, 1'b0, '0);
				repeat (ReaderLimit + 2)
					send_item(KIND_RELEASE, flood_key, MODE_SHARED, 1'b0, '0);
			end else begin
				pick = $urandom_range(0, 9);
				if (pick <= 5 || pick == 9) begin
					if (pick == 9)
						wait_until_settled();
					len = $urandom_range(20, 60);
					repeat (len) begin
						pick = $urandom_range(0, 99);
						if (pick < 40) begin
							send_item(KIND_ACQUIRE, key_pool[$urandom_range(0, PoolSize - 1)],
								($urandom_range(0, 9) < 4), 1'b0, '0);
						end else if (pick < 75) begin
							held_slots.delete();
							for (int s = 0; s < Entries; s++)
								if (held_valid[s])
									held_slots.push_back(s);
							if (held_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
								pick = held_slots[$urandom_range(0, held_slots.size() - 1)];
								send_item(KIND_RELEASE, held_key[pick], held_count[pick] < 0,
									1'b0, '0);
							end else begin
								send_item(KIND_RELEASE, key_pool[$urandom_range(0, PoolSize - 1)],
									1'($urandom_range(0, 1)), 1'b0, '0);
							end
						end else if (pick < 95) begin
							send_item(KIND_TEST, key_pool[$urandom_range(0, PoolSize - 1)],
								1'($urandom_range(0, 1)), 1'b0, '0);
						end else begin
							send_item(KIND_UNUSED, key_pool[$urandom_range(0, PoolSize - 1)],
								1'($urandom_range(0, 1)), 1'b0, '0);
						end
					end
				end else if (pick == 6) begin
					// Fill the table with fresh keys and run a few acquires into the full table.
					free_slots = 0;
					for (int s = 0; s < Entries; s++)
						if (!held_valid[s])
							free_slots++;
					repeat (free_slots + $urandom_range(1, 3))
						send_item(KIND_ACQUIRE, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
							1'b0, '0);
				end else if (pick == 7) begin
					drain_table();
				end else begin
					len = $urandom_range(5, 15);
					repeat (len)
						send_item(kind_t'($urandom_range(0, 3)), {$urandom, $urandom},
							1'($urandom_range(0, 1)), 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0)
			$display("keyed_reader_writer_lock_table_top_tb: PASS");
		else
			$display("keyed_reader_writer_lock_table_top_tb: FAIL");
		$finish;
	end

endmodule
